FILE: design/ast_pkg.sv
// Shared types, constants and character-class helpers for the assembly source tokenizer.
// No dependencies; imported by ast_scan, ast_fifo and assembly_source_tokenizer.
package ast_pkg;

  // Width of the pending-token length counter
  localparam int unsigned LENGTH_BITS = 8;
  // Width of the reported token length
  localparam int unsigned TOKLEN_W    = 8;
  // Result queue depth and pointer widths
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_UPPERF = 8'h46;
  localparam logic [7:0] CH_UPPERZ = 8'h5A;
  localparam logic [7:0] CH_LOWERA = 8'h61;
  localparam logic [7:0] CH_LOWERZ = 8'h7A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;

  typedef enum logic [3:0] {
    TK_COMMENT  = 4'd0,
    TK_NEWLINE  = 4'd1,
    TK_NAME     = 4'd2,
    TK_LABEL    = 4'd3,
    TK_HEX      = 4'd4,
    TK_DEC      = 4'd5,
    TK_LBRACKET = 4'd6,
    TK_RBRACKET = 4'd7,
    TK_COMMA    = 4'd8,
    TK_PLUS     = 4'd9,
    TK_END      = 4'd10,
    TK_ERROR    = 4'd11
  } tok_kind_e;

  // One result transaction
  typedef struct packed {
    tok_kind_e           kind;
    logic [TOKLEN_W-1:0] len;
    logic                last;
  } result_t;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[CH_LOWERA:CH_LOWERZ]}) || (c inside {[CH_UPPERA:CH_UPPERZ]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c inside {[CH_UPPERA:CH_UPPERF]}) || (c == CH_X);
  endfunction

  // Clamp the pending length to the reported width
  function automatic logic [TOKLEN_W-1:0] cap_len(logic [LENGTH_BITS-1:0] run);
    logic [15:0] ext;
    ext = 16'(run);
    return (ext > 16'd255) ? {TOKLEN_W{1'b1}} : ext[TOKLEN_W-1:0];
  endfunction

endpackage

FILE: design/ast_scan.sv
// Token scanner: holds the current mode and run length and turns one byte into
// up to two results. Depends on ast_pkg.
module ast_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        char_byte_i,
  output ast_pkg::push_t    push_o
);
  import ast_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_NAME    = 3'd2;
  localparam logic [2:0] MODE_LABEL   = 3'd3;
  localparam logic [2:0] MODE_DIGIT1  = 3'd4;
  localparam logic [2:0] MODE_DEC     = 3'd5;
  localparam logic [2:0] MODE_HEX     = 3'd6;

  logic [2:0]             mode_q, mode_d;
  logic [LENGTH_BITS-1:0] run_q, run_d;

  // Start-of-token decode
  logic                   st_emit;
  tok_kind_e              st_kind;
  logic [TOKLEN_W-1:0]    st_len;
  logic [2:0]             st_mode;
  logic                   st_one;

  // Pending-token decode
  logic                   pend;
  logic                   more;
  tok_kind_e              pend_kind;
  logic [2:0]             cont_mode;
  logic [LENGTH_BITS-1:0] run_inc;

  // Classify the byte as the first of a new token
  always_comb begin
    st_emit = 1'b0;
    st_kind = TK_ERROR;
    st_len  = TOKLEN_W'(1);
    st_mode = MODE_IDLE;
    st_one  = 1'b0;
    if (char_byte_i == CH_SPACE) begin
      st_emit = 1'b0;
    end else if (char_byte_i == CH_NUL) begin
      st_emit = 1'b1;
      st_kind = TK_END;
      st_len  = '0;
    end else if (char_byte_i == CH_SEMI) begin
      st_mode = MODE_COMMENT;
      st_one  = 1'b1;
    end else if (char_byte_i == CH_NL) begin
      st_emit = 1'b1;
      st_kind = TK_NEWLINE;
    end else if (is_letter(char_byte_i)) begin
      st_mode = MODE_NAME;
      st_one  = 1'b1;
    end else if (char_byte_i == CH_COLON) begin
      st_mode = MODE_LABEL;
      st_one  = 1'b1;
    end else if (is_digit(char_byte_i)) begin
      st_mode = MODE_DIGIT1;
      st_one  = 1'b1;
    end else if (char_byte_i == CH_LBRACK) begin
      st_emit = 1'b1;
      st_kind = TK_LBRACKET;
    end else if (char_byte_i == CH_RBRACK) begin
      st_emit = 1'b1;
      st_kind = TK_RBRACKET;
    end else if (char_byte_i == CH_COMMA) begin
      st_emit = 1'b1;
      st_kind = TK_COMMA;
    end else if (char_byte_i == CH_PLUS) begin
      st_emit = 1'b1;
      st_kind = TK_PLUS;
    end else begin
      st_emit = 1'b1;
      st_kind = TK_ERROR;
    end
  end

  // Decide whether the byte extends the pending token
  always_comb begin
    pend      = 1'b1;
    more      = 1'b0;
    pend_kind = TK_COMMENT;
    cont_mode = mode_q;
    case (mode_q)
      MODE_COMMENT: begin
        more      = (char_byte_i != CH_NL) && (char_byte_i != CH_NUL);
        pend_kind = TK_COMMENT;
      end
      MODE_NAME: begin
        more      = is_letter(char_byte_i);
        pend_kind = TK_NAME;
      end
      MODE_LABEL: begin
        more      = is_letter(char_byte_i);
        pend_kind = TK_LABEL;
      end
      MODE_DIGIT1: begin
        pend_kind = TK_DEC;
        if (char_byte_i == CH_X) begin
          more      = 1'b1;
          cont_mode = MODE_HEX;
        end else if (is_digit(char_byte_i)) begin
          more      = 1'b1;
          cont_mode = MODE_DEC;
        end
      end
      MODE_DEC: begin
        more      = is_digit(char_byte_i);
        pend_kind = TK_DEC;
      end
      MODE_HEX: begin
        more      = is_hex(char_byte_i);
        pend_kind = TK_HEX;
      end
      default: begin
        pend = 1'b0;
      end
    endcase
  end

  // Saturating length increment
  assign run_inc = (run_q == {LENGTH_BITS{1'b1}}) ? run_q : run_q + LENGTH_BITS'(1);

  // Build results and next state
  always_comb begin
    push_o = '0;
    mode_d = mode_q;
    run_d  = run_q;
    if (pend && more) begin
      mode_d = cont_mode;
      run_d  = run_inc;
    end else begin
      mode_d = st_mode;
      run_d  = st_one ? LENGTH_BITS'(1) : '0;
      if (pend) begin
        push_o.r0.kind = pend_kind;
        push_o.r0.len  = cap_len(run_q);
        push_o.r0.last = !st_emit;
        push_o.r1.kind = st_kind;
        push_o.r1.len  = st_len;
        push_o.r1.last = 1'b1;
        push_o.num     = st_emit ? 2'd2 : 2'd1;
      end else begin
        push_o.r0.kind = st_kind;
        push_o.r0.len  = st_len;
        push_o.r0.last = 1'b1;
        push_o.num     = st_emit ? 2'd1 : 2'd0;
      end
    end
  end

  // Advance scan state on each input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      run_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      run_q  <= run_d;
    end
  end

  // A zero byte always leaves the scanner idle and empty
  a_nul_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (char_byte_i == CH_NUL) |=> (mode_q == MODE_IDLE) && (run_q == '0))
    else $error("zero byte did not return scanner to idle");

  // A letter seen between tokens opens a name of length one
  a_letter_opens_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (mode_q == MODE_IDLE) && is_letter(char_byte_i)
    |=> (mode_q == MODE_NAME) && (run_q == LENGTH_BITS'(1)))
    else $error("letter did not open a name token");

  // The unused mode code is never entered
  a_no_mode7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> mode_q != 3'd7)
    else $error("scanner entered unused mode");

endmodule

FILE: design/ast_fifo.sv
// Result queue: takes up to two results per cycle and hands out one per
// transaction. Depends on ast_pkg.
module ast_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_en_i,
  input  ast_pkg::push_t     push_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ast_pkg::result_t   head_o
);
  import ast_pkg::*;

  result_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [1:0]           push_n;
  logic                 pop;
  logic [PTR_W-1:0]     wr_ptr_nx;

  assign push_n      = push_en_i ? push_i.num : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  // Room for a worst-case pair of results
  assign space_o     = (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + PTR_W'(1);
  assign count_d     = count_q + CNT_W'(push_n) - CNT_W'(pop);

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // Occupancy never exceeds the depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Occupancy tracks the pointer distance
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(count_q) == PTR_W'(wr_ptr_q - rd_ptr_q)))
    else $error("queue pointers disagree with count");

  // Push only while room for a pair of results remains
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en_i |-> (count_q <= CNT_W'(FIFO_DEPTH - 2)))
    else $error("push into a queue without room");

endmodule

FILE: design/assembly_source_tokenizer.sv
// Top level of the assembly source tokenizer: scanner plus result queue.
// Depends on ast_pkg, ast_scan and ast_fifo.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/char_byte_i) carries one source
//   byte per transaction; a zero byte flushes any pending token and yields
//   an end token. Output channel (out_valid_o/out_ready_i) carries one token
//   per transaction: token_kind_o, token_length_o and last_o, which marks the
//   final result caused by a given byte.
//   Results are written into the four-entry result queue when the byte
//   that completes the token is accepted, and leave it in order.
//   Throughput: one byte per cycle while in_ready_o is high. Each byte yields
//   zero, one or two results; the output side drains one per cycle while
//   out_ready_i is high, so a byte that yields two grows the queue by one.
//   Input is accepted whenever the queue holds two or fewer results; when
//   the receiver stalls the queue fills and in_ready_o drops until room for
//   two more results is back.
//   Reset clears the scanner to idle with zero length and empties the queue.
module assembly_source_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  token_length_o,
  output logic        last_o
);
  import ast_pkg::*;

  logic    fire;
  push_t   push;
  result_t head;

  assign fire = in_valid_i && in_ready_o;

  // Scan bytes into results
  ast_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .char_byte_i (char_byte_i),
    .push_o      (push)
  );

  // Queue results toward the receiver
  ast_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign token_kind_o   = head.kind;
  assign token_length_o = head.len;
  assign last_o         = head.last;

  // A zero byte always produces a final end token
  a_nul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (char_byte_i == CH_NUL)
    |-> (push.num != 2'd0) && ((push.num == 2'd1) ? (push.r0.kind == TK_END)
                                                  : (push.r1.kind == TK_END)))
    else $error("zero byte did not produce end token");

  // Hold a waiting result steady until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
    |=> out_valid_o && $stable({token_kind_o, token_length_o, last_o}))
    else $error("waiting result changed before transaction");

  // Input only stalls while results are waiting
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty queue");

endmodule
